>>> rtl/kdq_pkg.sv
// Package for the keypad debounce queue: payload types, config codes and reset values.
`default_nettype none

package kdq_pkg;

    localparam int KDQ_QUEUE_DEPTH = 8;

    localparam int KEY_W   = 4;
    localparam int READS_W = 8;
    localparam int FILL_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_READS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_KEY_CODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_OR_INFO_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_CODE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE         = 3'd4;

    localparam logic [READS_W-1:0] RST_STABLE_READS    = 8'd5;
    localparam logic [KEY_W-1:0]   RST_NO_KEY_CODE     = 4'd0;
    localparam logic [KEY_W-1:0]   RST_UP_OR_INFO_CODE = 4'd1;
    localparam logic [KEY_W-1:0]   RST_INFO_CODE       = 4'd2;
    localparam logic [KEY_W-1:0]   RST_UP_CODE         = 4'd3;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] raw_key;
    } in_data_t;

    typedef struct packed {
        logic [KEY_W-1:0]  popped_key;
        logic              pop_hit;
        logic              key_queued;
        logic              key_dropped;
        logic              sampling_busy;
        logic [FILL_W-1:0] queue_fill;
    } out_data_t;

    typedef struct packed {
        logic [READS_W-1:0] stable_reads;
        logic [KEY_W-1:0]   no_key_code;
        logic [KEY_W-1:0]   up_or_info_code;
        logic [KEY_W-1:0]   info_code;
        logic [KEY_W-1:0]   up_code;
    } cfg_t;

    // Stable key handed from the debouncer to the queue
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             armed_next;
    } offer_t;

    // Shared control for the row of queue cells
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/kdq_cell.sv
// One queue entry: loads a pushed key when selected, takes its neighbor's key on a pop.
`default_nettype none

module kdq_cell (
    input  wire logic                     clk,
    input  wire kdq_pkg::cell_ctrl_t      ctrl,
    input  wire logic                     sel,
    input  wire logic [kdq_pkg::KEY_W-1:0] next_key,
    output logic      [kdq_pkg::KEY_W-1:0] key
);
    import kdq_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    always_comb
    begin
        key_next = key_reg;
        priority if (ctrl.pop)
        begin
            key_next = next_key;
        end
        else if (ctrl.push && sel)
        begin
            key_next = ctrl.key;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

`default_nettype wire

>>> rtl/kdq_sampler.sv
// Debounce sampler with the shared up/info key combination logic.
`default_nettype none

module kdq_sampler (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      tick,
    input  wire logic [kdq_pkg::KEY_W-1:0] raw_key,
    input  wire kdq_pkg::cfg_t             cfg,
    output kdq_pkg::offer_t                offer
);
    import kdq_pkg::*;

    typedef enum logic [1:0] {
        COMBO_NONE    = 2'd0,
        COMBO_PENDING = 2'd1,
        COMBO_INFO    = 2'd2
    } combo_t;

    logic [KEY_W-1:0]   last_key_reg,   last_key_next;
    logic [READS_W-1:0] reads_left_reg, reads_left_next;
    logic               armed_reg,      armed_next;
    combo_t             combo_reg,      combo_next;

    logic [READS_W-1:0] reads_dec;
    logic               stable;
    logic [KEY_W-1:0]   key;

    always_comb
    begin
        last_key_next   = last_key_reg;
        reads_left_next = reads_left_reg;
        armed_next      = armed_reg;
        combo_next      = combo_reg;
        reads_dec       = reads_left_reg - 8'd1;
        stable          = 1'b0;
        key             = raw_key;

        if (tick)
        begin
            if (!armed_reg)
            begin
                // arming tick does not count down
                if (raw_key != last_key_reg)
                begin
                    last_key_next   = raw_key;
                    reads_left_next = cfg.stable_reads;
                    armed_next      = 1'b1;
                end
            end
            else if (raw_key != last_key_reg)
            begin
                last_key_next   = raw_key;
                reads_left_next = cfg.stable_reads;
            end
            else if (reads_dec != '0)
            begin
                reads_left_next = reads_dec;
            end
            else if (raw_key == cfg.up_or_info_code)
            begin
                // shared key waits for the next stable key
                if (combo_reg == COMBO_NONE)
                begin
                    combo_next = COMBO_PENDING;
                end
                reads_left_next = cfg.stable_reads;
            end
            else
            begin
                armed_next      = 1'b0;
                reads_left_next = reads_dec;
                stable          = 1'b1;
                if (raw_key == cfg.info_code)
                begin
                    combo_next = COMBO_INFO;
                end
                else
                begin
                    if (combo_reg == COMBO_PENDING)
                    begin
                        key = cfg.up_code;
                    end
                    combo_next = COMBO_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg   <= RST_NO_KEY_CODE;
            reads_left_reg <= RST_STABLE_READS;
            armed_reg      <= 1'b0;
            combo_reg      <= COMBO_NONE;
        end
        else
        begin
            last_key_reg   <= last_key_next;
            reads_left_reg <= reads_left_next;
            armed_reg      <= armed_next;
            combo_reg      <= combo_next;
        end
    end

    always_comb
    begin
        offer.valid      = stable && (key > cfg.no_key_code);
        offer.key        = key;
        offer.armed_next = armed_next;
    end

endmodule

`default_nettype wire

>>> rtl/keypad_debounce_queue_top.sv
// Keypad debouncer feeding a queue of stable keys built as a row of shifting cells.
//
// Input channel (in_valid/in_stall/in_data) carries one request per item:
// a sample tick with the raw keypad code, or a pop of the oldest queued key.
// Each request yields exactly one result on the output channel
// (out_valid/out_stall/out_data), in order.
// out_valid rises in the cycle after a request is accepted. One request is taken
// per cycle while in_stall is low; the debouncer and queue update directly from
// the accepted request, and the queue cells all shift together on a pop.
// The output register frees in the cycle its result is taken, so in_stall is
// high only while a result is held and out_stall is high.
// Configuration is written via cfg_we/cfg_index/cfg_data, by the user only while
// idle (unenforced); it applies to the next request. Higher indexes are ignored.
// Reset (rst_n low, asynchronous) restores register defaults, disarms the
// sampler, clears the pending combination and empties the queue. The queue
// contents themselves are not cleared; entries past the fill count are never read.
`default_nettype none

module keypad_debounce_queue_top #(
    parameter int QUEUE_DEPTH = kdq_pkg::KDQ_QUEUE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire kdq_pkg::in_data_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output kdq_pkg::out_data_t                  out_data,
    input  wire logic                           cfg_we,
    input  wire logic [kdq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kdq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kdq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t             cfg_reg;
    logic             out_valid_reg, out_valid_next;
    out_data_t        out_data_reg,  out_data_next;
    logic [CNT_W-1:0] fill_reg,      fill_next;

    logic       accept;
    logic       tick;
    logic       pop_req;
    logic       full;
    offer_t     offer;
    cell_ctrl_t ctrl;

    logic [KEY_W-1:0] cell_key [QUEUE_DEPTH+1];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tick     = accept && (in_data.operation == OP_TICK);
    assign pop_req  = accept && (in_data.operation == OP_POP);
    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_reads    <= RST_STABLE_READS;
            cfg_reg.no_key_code     <= RST_NO_KEY_CODE;
            cfg_reg.up_or_info_code <= RST_UP_OR_INFO_CODE;
            cfg_reg.info_code       <= RST_INFO_CODE;
            cfg_reg.up_code         <= RST_UP_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STABLE_READS:    cfg_reg.stable_reads    <= cfg_data;
                CFG_NO_KEY_CODE:     cfg_reg.no_key_code     <= cfg_data[KEY_W-1:0];
                CFG_UP_OR_INFO_CODE: cfg_reg.up_or_info_code <= cfg_data[KEY_W-1:0];
                CFG_INFO_CODE:       cfg_reg.info_code       <= cfg_data[KEY_W-1:0];
                CFG_UP_CODE:         cfg_reg.up_code         <= cfg_data[KEY_W-1:0];
                default:             ;
            endcase
        end
    end

    kdq_sampler u_sampler (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .raw_key (in_data.raw_key),
        .cfg     (cfg_reg),
        .offer   (offer)
    );

    always_comb
    begin
        ctrl.push = offer.valid && !full;
        ctrl.pop  = pop_req && (fill_reg != '0);
        ctrl.key  = offer.key;
    end

    // Row of queue cells; cell 0 is the head
    assign cell_key[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        kdq_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .sel      (fill_reg == CNT_W'(i)),
            .next_key (cell_key[i+1]),
            .key      (cell_key[i])
        );
    end

    always_comb
    begin
        fill_next = fill_reg;
        priority if (ctrl.push)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next              = 1'b1;
            out_data_next.popped_key    = ctrl.pop ? cell_key[0] : cfg_reg.no_key_code;
            out_data_next.pop_hit       = ctrl.pop;
            out_data_next.key_queued    = ctrl.push;
            out_data_next.key_dropped   = offer.valid && full;
            out_data_next.sampling_busy = offer.armed_next;
            out_data_next.queue_fill    = (int'(fill_next) > 15) ? 4'd15 : FILL_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
